// ===== hw/rtl/sacd_pkg.sv =====
// ----------------------------------------------------------------------------
// sacd_pkg
// Shared types, codes and default sizes of the set associative directory.
// ----------------------------------------------------------------------------
`default_nettype none

package sacd_pkg;

    localparam int BUCKET_COUNT_DEF = 1024;
    localparam int WAYS_DEF         = 4;

    localparam int OFF_W    = 40;
    localparam int TAG_W    = 12;

    // Request codes
    typedef enum logic [2:0] {
        REQ_PROBE      = 3'd0,
        REQ_INSERT     = 3'd1,
        REQ_REMOVE     = 3'd2,
        REQ_REMOVE_AT  = 3'd3,
        REQ_TOGGLE     = 3'd4
    } req_code_t;

    // Insert outcome codes
    typedef enum logic [2:0] {
        OUT_NONE     = 3'd0,
        OUT_UPDATED  = 3'd1,
        OUT_EMPTY    = 3'd2,
        OUT_STALE    = 3'd3,
        OUT_COLLIDER = 3'd4,
        OUT_LOWEST   = 3'd5,
        OUT_FAILED   = 3'd6
    } outcome_t;

    // One directory entry; offset zero marks it empty
    typedef struct packed {
        logic             head;
        logic             phase;
        logic [TAG_W-1:0] tag;
        logic [5:0]       blocks;
        logic [1:0]       scale;
        logic [OFF_W-1:0] offset;
    } entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_we;
        logic latch;
        logic read;
        logic exec;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_done;
        logic out_busy;
    } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sacd_ctrl.sv =====
// ----------------------------------------------------------------------------
// sacd_ctrl
// Sequencer: clearing sweep after reset, then accept, read row, evaluate.
// ----------------------------------------------------------------------------
`default_nettype none

module sacd_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire sacd_pkg::status_t status,
    output sacd_pkg::cmd_t         cmd
);

    sacd_pkg::state_t state_reg;
    sacd_pkg::state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sacd_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance through the request steps
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        unique case (state_reg)
            sacd_pkg::ST_CLEAR:
            begin
                cmd.clear_we = 1'b1;
                if (status.clear_done)
                begin
                    state_next = sacd_pkg::ST_IDLE;
                end
            end
            sacd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = sacd_pkg::ST_READ;
                end
            end
            sacd_pkg::ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = sacd_pkg::ST_EVAL;
            end
            sacd_pkg::ST_EVAL:
            begin
                if (!status.out_busy)
                begin
                    cmd.exec   = 1'b1;
                    state_next = sacd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sacd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sacd_datapath.sv =====
// ----------------------------------------------------------------------------
// sacd_datapath
// Bucket row memory, request registers, way evaluation and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sacd_datapath #(
    parameter int BUCKET_COUNT = sacd_pkg::BUCKET_COUNT_DEF,
    parameter int WAYS         = sacd_pkg::WAYS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire sacd_pkg::cmd_t cmd,
    output sacd_pkg::status_t   status,
    input  wire logic [2:0]     req_type,
    input  wire logic [9:0]     bucket,
    input  wire logic [11:0]    key_tag,
    input  wire logic [39:0]    store_offset,
    input  wire logic [39:0]    doc_bytes,
    input  wire logic [39:0]    known_offset,
    input  wire logic           match_any,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic                success,
    output logic [1:0]          way,
    output logic [2:0]          outcome,
    output logic [39:0]         entry_offset,
    output logic [1:0]          entry_scale,
    output logic [5:0]          entry_blocks,
    output logic                entry_head,
    output logic [2:0]          removed_count,
    output logic [12:0]         entries_in_use
);

    localparam int BW     = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int WW     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int NW     = $clog2(WAYS + 1);
    localparam int CW     = $clog2(BUCKET_COUNT * WAYS + 1);
    localparam int RECIP  = ((1 << 20) + BUCKET_COUNT - 1) / BUCKET_COUNT;

    // Byte size to {blocks minus one, scale}
    function automatic logic [7:0] size_code(input logic [39:0] b);
        logic [1:0]  sc;
        logic [40:0] sum;
        logic [40:0] blk;
        logic [6:0]  cnt;
        if (b <= 40'd32768)
            sc = 2'd0;
        else if (b <= 40'd65536)
            sc = 2'd1;
        else if (b <= 40'd131072)
            sc = 2'd2;
        else
            sc = 2'd3;
        sum = {1'b0, b} + ((41'd512 << sc) - 41'd1);
        blk = sum >> (6'd9 + 6'(sc));
        if (blk == '0)
            cnt = 7'd1;
        else if (blk > 41'd64)
            cnt = 7'd64;
        else
            cnt = blk[6:0];
        return {6'(cnt - 7'd1), sc};
    endfunction

    sacd_pkg::entry_t [WAYS-1:0] mem [BUCKET_COUNT];

    sacd_pkg::entry_t [WAYS-1:0] row_reg;
    sacd_pkg::entry_t [WAYS-1:0] row_next;
    logic [BW-1:0]  clr_cnt_reg;
    logic [9:0]     bkt_reg;
    logic [9:0]     quot_reg;
    logic [BW-1:0]  row_idx;
    logic [BW-1:0]  row_idx_reg;
    logic [2:0]     req_reg;
    logic [11:0]    tag_reg;
    logic [39:0]    off_reg;
    logic [39:0]    bytes_reg;
    logic [39:0]    voff_reg;
    logic           any_reg;
    logic           phase_reg;
    logic           phase_next;
    logic [CW-1:0]  live_reg;
    logic [CW-1:0]  live_next;
    logic [30:0]    quot_prod;
    logic [31:0]    rem_full;

    logic           out_valid_reg;
    logic           r_success;
    logic [WW-1:0]  r_way;
    logic [2:0]     r_outcome;
    logic [39:0]    r_offset;
    logic [1:0]     r_scale;
    logic [5:0]     r_blocks;
    logic           r_head;
    logic [NW-1:0]  r_removed;
    logic           success_reg;
    logic [1:0]     way_reg;
    logic [2:0]     outcome_reg;
    logic [39:0]    offset_reg;
    logic [1:0]     scale_reg;
    logic [5:0]     blocks_reg;
    logic           head_reg;
    logic [2:0]     removed_reg;
    logic [12:0]    in_use_reg;

    // Bucket modulo count: quotient by reciprocal at accept, remainder next
    assign quot_prod = 31'(bucket) * 31'(RECIP);
    assign rem_full  = 32'(bkt_reg) - 32'(quot_reg) * 32'(BUCKET_COUNT);
    assign row_idx   = BW'(rem_full);

    assign status.clear_done = (clr_cnt_reg == BW'(BUCKET_COUNT - 1));
    assign status.out_busy   = out_valid_reg && !out_ready;

    // Sweep counter for the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_we && !status.clear_done)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // Row memory: clear, read, write back
    always_ff @(posedge clk)
    begin
        if (cmd.clear_we)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.exec)
        begin
            mem[row_idx_reg] <= row_next;
        end
        if (cmd.read)
        begin
            row_reg <= mem[row_idx];
        end
    end

    // Capture request fields
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg   <= req_type;
            bkt_reg   <= bucket;
            quot_reg  <= 10'(quot_prod >> 20);
            tag_reg   <= key_tag;
            off_reg   <= store_offset;
            bytes_reg <= doc_bytes;
            voff_reg  <= known_offset;
            any_reg   <= match_any;
        end
        if (cmd.read)
        begin
            row_idx_reg <= row_idx;
        end
    end

    // Evaluate all ways of the row
    always_comb
    begin
        logic          hit;
        logic [WW-1:0] hit_idx;
        logic          f_tgt, f_emp, f_stl, f_col, f_low;
        logic [WW-1:0] i_tgt, i_emp, i_stl, i_col, i_low;
        logic [39:0]   low_off;
        logic          rm_hit;
        logic [WW-1:0] rm_idx;
        logic [NW-1:0] n_at;
        logic [WW-1:0] at_idx;
        logic          cur_match;
        logic [WW-1:0] pick;
        logic [7:0]    code;
        logic [CW-1:0] n_wide;

        hit = 1'b0;  hit_idx = '0;
        f_tgt = 1'b0; f_emp = 1'b0; f_stl = 1'b0; f_col = 1'b0; f_low = 1'b0;
        i_tgt = '0; i_emp = '0; i_stl = '0; i_col = '0; i_low = '0;
        low_off = '0;
        rm_hit = 1'b0; rm_idx = '0;
        n_at = '0; at_idx = '0;
        pick = '0;
        code = size_code(bytes_reg);
        n_wide = '0;

        row_next   = row_reg;
        phase_next = phase_reg;
        live_next  = live_reg;
        r_success  = 1'b0;
        r_way      = '0;
        r_outcome  = sacd_pkg::OUT_NONE;
        r_offset   = '0;
        r_scale    = '0;
        r_blocks   = '0;
        r_head     = 1'b0;
        r_removed  = '0;

        for (int i = 0; i < WAYS; i++)
        begin
            cur_match = (row_reg[i].offset != '0) && (row_reg[i].phase == phase_reg)
                        && (row_reg[i].tag == tag_reg);
            if (cur_match && !hit)
            begin
                hit     = 1'b1;
                hit_idx = WW'(i);
            end
            if (row_reg[i].offset == '0)
            begin
                if (!f_emp)
                begin
                    f_emp = 1'b1;
                    i_emp = WW'(i);
                end
            end
            else
            begin
                if (!f_low || row_reg[i].offset < low_off)
                begin
                    f_low   = 1'b1;
                    i_low   = WW'(i);
                    low_off = row_reg[i].offset;
                end
                if (cur_match)
                begin
                    if (any_reg || row_reg[i].offset == voff_reg)
                    begin
                        if (!f_tgt)
                        begin
                            f_tgt = 1'b1;
                            i_tgt = WW'(i);
                        end
                    end
                    else if (!f_col)
                    begin
                        f_col = 1'b1;
                        i_col = WW'(i);
                    end
                end
                else if (row_reg[i].phase != phase_reg && !f_stl)
                begin
                    f_stl = 1'b1;
                    i_stl = WW'(i);
                end
                if (row_reg[i].tag == tag_reg && !rm_hit)
                begin
                    rm_hit = 1'b1;
                    rm_idx = WW'(i);
                end
            end
        end

        unique case (req_reg)
            sacd_pkg::REQ_PROBE:
            begin
                if (hit)
                begin
                    r_success = 1'b1;
                    r_way     = hit_idx;
                    r_offset  = row_reg[hit_idx].offset;
                    r_scale   = row_reg[hit_idx].scale;
                    r_blocks  = row_reg[hit_idx].blocks;
                    r_head    = row_reg[hit_idx].head;
                end
            end
            sacd_pkg::REQ_INSERT:
            begin
                if (off_reg == '0)
                begin
                    r_outcome = sacd_pkg::OUT_FAILED;
                end
                else
                begin
                    if (f_tgt)
                    begin
                        pick = i_tgt; r_outcome = sacd_pkg::OUT_UPDATED;
                    end
                    else if (f_emp)
                    begin
                        pick = i_emp; r_outcome = sacd_pkg::OUT_EMPTY;
                    end
                    else if (f_stl)
                    begin
                        pick = i_stl; r_outcome = sacd_pkg::OUT_STALE;
                    end
                    else if (f_col)
                    begin
                        pick = i_col; r_outcome = sacd_pkg::OUT_COLLIDER;
                    end
                    else
                    begin
                        pick = i_low; r_outcome = sacd_pkg::OUT_LOWEST;
                    end
                    row_next[pick].offset = off_reg;
                    row_next[pick].scale  = code[1:0];
                    row_next[pick].blocks = code[7:2];
                    row_next[pick].phase  = phase_reg;
                    if (!f_tgt)
                    begin
                        row_next[pick].tag  = tag_reg;
                        row_next[pick].head = 1'b1;
                    end
                    if (!f_tgt && f_emp)
                    begin
                        live_next = live_reg + 1'b1;
                    end
                    r_success = 1'b1;
                    r_way     = pick;
                end
            end
            sacd_pkg::REQ_REMOVE:
            begin
                if (rm_hit)
                begin
                    row_next[rm_idx] = '0;
                    if (live_reg != '0)
                    begin
                        live_next = live_reg - 1'b1;
                    end
                    r_success = 1'b1;
                    r_way     = rm_idx;
                    r_removed = NW'(1);
                end
            end
            sacd_pkg::REQ_REMOVE_AT:
            begin
                for (int i = WAYS - 1; i >= 0; i--)
                begin
                    if (row_reg[i].offset != '0 && row_reg[i].tag == tag_reg
                        && row_reg[i].offset == off_reg)
                    begin
                        row_next[i] = '0;
                        n_at        = n_at + 1'b1;
                        at_idx      = WW'(i);
                    end
                end
                n_wide = CW'(n_at);
                if (live_reg >= n_wide)
                begin
                    live_next = live_reg - n_wide;
                end
                else
                begin
                    live_next = '0;
                end
                r_success = (n_at != '0);
                r_way     = at_idx;
                r_removed = n_at;
            end
            sacd_pkg::REQ_TOGGLE:
            begin
                phase_next = !phase_reg;
            end
            default:
            begin
                r_success = 1'b0;
            end
        endcase
    end

    // Update phase and live count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            live_reg  <= '0;
        end
        else if (cmd.exec)
        begin
            phase_reg <= phase_next;
            live_reg  <= live_next;
        end
    end

    // Result beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            success_reg <= r_success;
            way_reg     <= 2'(r_way);
            outcome_reg <= r_outcome;
            offset_reg  <= r_offset;
            scale_reg   <= r_scale;
            blocks_reg  <= r_blocks;
            head_reg    <= r_head;
            removed_reg <= 3'(r_removed);
            in_use_reg  <= 13'(live_next);
        end
    end

    assign out_valid      = out_valid_reg;
    assign success        = success_reg;
    assign way            = way_reg;
    assign outcome        = outcome_reg;
    assign entry_offset   = offset_reg;
    assign entry_scale    = scale_reg;
    assign entry_blocks   = blocks_reg;
    assign entry_head     = head_reg;
    assign removed_count  = removed_reg;
    assign entries_in_use = in_use_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/set_assoc_cache_directory_core.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_directory_core
// Set associative directory with phase bit: probe, insert, remove, toggle.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Beat contents
//  in        in_valid / in_ready    req_type, bucket, key_tag, offsets, size
//  out       out_valid / out_ready  success, way, outcome, entry, counts
//
//  Each request passes through accept (bucket quotient), row read, then
//  evaluate and write back, one request at a time.
//  After reset a clearing pass writes BUCKET_COUNT rows, one per cycle,
//  and no request is accepted until it ends.
//  A held result stalls evaluation, and no new request is taken until evaluation completes.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_directory_core #(
    parameter int BUCKET_COUNT = sacd_pkg::BUCKET_COUNT_DEF,
    parameter int WAYS         = sacd_pkg::WAYS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  req_type,
    input  wire logic [9:0]  bucket,
    input  wire logic [11:0] key_tag,
    input  wire logic [39:0] store_offset,
    input  wire logic [39:0] doc_bytes,
    input  wire logic [39:0] known_offset,
    input  wire logic        match_any,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             success,
    output logic [1:0]       way,
    output logic [2:0]       outcome,
    output logic [39:0]      entry_offset,
    output logic [1:0]       entry_scale,
    output logic [5:0]       entry_blocks,
    output logic             entry_head,
    output logic [2:0]       removed_count,
    output logic [12:0]      entries_in_use
);

    sacd_pkg::cmd_t    cmd;
    sacd_pkg::status_t status;

    sacd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    sacd_datapath #(
        .BUCKET_COUNT (BUCKET_COUNT),
        .WAYS         (WAYS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .req_type        (req_type),
        .bucket          (bucket),
        .key_tag         (key_tag),
        .store_offset    (store_offset),
        .doc_bytes       (doc_bytes),
        .known_offset    (known_offset),
        .match_any       (match_any),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .success         (success),
        .way             (way),
        .outcome         (outcome),
        .entry_offset    (entry_offset),
        .entry_scale     (entry_scale),
        .entry_blocks    (entry_blocks),
        .entry_head      (entry_head),
        .removed_count   (removed_count),
        .entries_in_use  (entries_in_use)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/sacd_checker.sv =====
// ----------------------------------------------------------------------------
// sacd_checker
// Port-level checks of the directory core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sacd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        success,
    input wire logic [2:0]  outcome,
    input wire logic [39:0] entry_offset,
    input wire logic [2:0]  removed_count
);

    // One request in flight: no accept right after an accept
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted back to back");

    // Held result beat stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // Failing requests carry no entry and no outcome other than none or failed
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !success |-> entry_offset == '0 && removed_count == '0
            && (outcome == sacd_pkg::OUT_NONE || outcome == sacd_pkg::OUT_FAILED))
        else $error("failed request with payload");

    // Results that report removed entries are not inserts and succeed
    a_remove: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && removed_count != '0 |-> success && outcome == sacd_pkg::OUT_NONE
            && entry_offset == '0)
        else $error("inconsistent removal result");

    // A found entry comes only from a probe hit
    a_probe: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && entry_offset != '0 |-> success && outcome == sacd_pkg::OUT_NONE)
        else $error("entry reported outside probe hit");

endmodule

bind set_assoc_cache_directory_core sacd_checker u_sacd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .success       (success),
    .outcome       (outcome),
    .entry_offset  (entry_offset),
    .removed_count (removed_count)
);

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Directory core testbench
// Drives directed and random probe, insert, remove and toggle requests and checks
// each result against a behavioral copy of the bucketed directory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct packed {
    logic        success;
    logic [1:0]  way;
    logic [2:0]  outcome;
    logic [39:0] entry_offset;
    logic [1:0]  entry_scale;
    logic [5:0]  entry_blocks;
    logic        entry_head;
    logic [2:0]  removed_count;
    logic [12:0] entries_in_use;
} dir_resp_t;

class dir_scoreboard;
    logic [47:0] loc [4096];
    logic [13:0] tags [4096];
    logic        phase;
    int          live;
    dir_resp_t   pending [$];
    int          errors;
    int          checked;

    function new();
        foreach (loc[i]) begin
            loc[i] = '0;
            tags[i] = '0;
        end
        phase = 0;
        live = 0;
        errors = 0;
        checked = 0;
    endfunction

    function logic [7:0] size_code(logic [39:0] bytes);
        logic [63:0] unit;
        logic [63:0] blocks;
        int          s;
        s = 0;
        while (s < 3 && {24'd0, bytes} > (64'd64 * 64'd512 << s))
            s++;
        unit = 64'd512 << s;
        blocks = ({24'd0, bytes} + unit - 1) / unit;
        if (blocks == 0)
            blocks = 1;
        if (blocks > 64)
            blocks = 64;
        return {blocks[5:0] - 6'd1, s[1:0]};
    endfunction

    // Compute the response of one accepted request and update the directory
    function void note_request(logic [2:0] rq, logic [9:0] bkt, logic [11:0] tg,
                               logic [39:0] off, logic [39:0] bytes,
                               logic [39:0] voff, logic any);
        dir_resp_t r;
        int        base;
        int        s;
        int        target, empty, stale, coll, low, pick, n;
        logic [39:0] o, low_off;
        logic [2:0]  code;
        logic [7:0]  sc;
        r = '{default: '0};
        base = bkt * 4;
        target = -1; empty = -1; stale = -1; coll = -1; low = -1;
        low_off = '0;
        n = 0;
        case (rq)
            sacd_pkg::REQ_PROBE: begin
                for (int i = 0; i < 4; i++) begin
                    s = base + i;
                    if (loc[s][39:0] != 0 && tags[s][12] == phase && tags[s][11:0] == tg)
                    begin
                        r.success = 1;
                        r.way = 2'(i);
                        r.entry_offset = loc[s][39:0];
                        r.entry_scale = loc[s][41:40];
                        r.entry_blocks = loc[s][47:42];
                        r.entry_head = tags[s][13];
                        break;
                    end
                end
            end
            sacd_pkg::REQ_INSERT: begin
                if (off == 0) begin
                    r.outcome = sacd_pkg::OUT_FAILED;
                end else begin
                    for (int i = 0; i < 4; i++) begin
                        s = base + i;
                        o = loc[s][39:0];
                        if (o == 0) begin
                            if (empty < 0)
                                empty = i;
                            continue;
                        end
                        if (low < 0 || o < low_off) begin
                            low = i;
                            low_off = o;
                        end
                        if (tags[s][11:0] == tg && tags[s][12] == phase) begin
                            if (any || o == voff) begin
                                target = i;
                                break;
                            end
                            if (coll < 0)
                                coll = i;
                            continue;
                        end
                        if (tags[s][12] != phase && stale < 0)
                            stale = i;
                    end
                    if (target >= 0) begin
                        pick = target; code = sacd_pkg::OUT_UPDATED;
                    end else if (empty >= 0) begin
                        pick = empty; code = sacd_pkg::OUT_EMPTY;
                    end else if (stale >= 0) begin
                        pick = stale; code = sacd_pkg::OUT_STALE;
                    end else if (coll >= 0) begin
                        pick = coll; code = sacd_pkg::OUT_COLLIDER;
                    end else begin
                        pick = low; code = sacd_pkg::OUT_LOWEST;
                    end
                    s = base + pick;
                    sc = size_code(bytes);
                    loc[s] = {sc[7:2], sc[1:0], off};
                    if (code == sacd_pkg::OUT_UPDATED)
                        tags[s] = {tags[s][13], phase, tags[s][11:0]};
                    else
                        tags[s] = {1'b1, phase, tg};
                    if (code == sacd_pkg::OUT_EMPTY)
                        live++;
                    r.success = 1;
                    r.way = 2'(pick);
                    r.outcome = code;
                end
            end
            sacd_pkg::REQ_REMOVE: begin
                for (int i = 0; i < 4; i++) begin
                    s = base + i;
                    if (loc[s][39:0] != 0 && tags[s][11:0] == tg) begin
                        loc[s] = '0;
                        tags[s] = '0;
                        if (live > 0)
                            live--;
                        r.success = 1;
                        r.way = 2'(i);
                        r.removed_count = 3'd1;
                        break;
                    end
                end
            end
            sacd_pkg::REQ_REMOVE_AT: begin
                for (int i = 0; i < 4; i++) begin
                    s = base + i;
                    if (loc[s][39:0] != 0 && tags[s][11:0] == tg && loc[s][39:0] == off)
                    begin
                        if (n == 0)
                            r.way = 2'(i);
                        loc[s] = '0;
                        tags[s] = '0;
                        n++;
                        if (live > 0)
                            live--;
                    end
                end
                r.success = (n != 0);
                r.removed_count = 3'(n);
            end
            sacd_pkg::REQ_TOGGLE: phase = ~phase;
            default: ;
        endcase
        r.entries_in_use = 13'(live);
        pending = {pending, r};
    endfunction

    function void check_response(dir_resp_t a);
        dir_resp_t e;
        checked++;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected response beat: success=%0d way=%0d", a.success, a.way);
            return;
        end
        e = pending.pop_front();
        if (a !== e) begin
            errors++;
            if (errors <= 10)
                $display("mismatch #%0d: exp %p act %p", checked, e, a);
        end
    endfunction
endclass

module tb;
    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [2:0]  req_type = '0;
    logic [9:0]  bucket = '0;
    logic [11:0] key_tag = '0;
    logic [39:0] store_offset = '0;
    logic [39:0] doc_bytes = '0;
    logic [39:0] known_offset = '0;
    logic        match_any = 0;
    logic        out_valid;
    logic        out_ready = 0;
    logic        success;
    logic [1:0]  way;
    logic [2:0]  outcome;
    logic [39:0] entry_offset;
    logic [1:0]  entry_scale;
    logic [5:0]  entry_blocks;
    logic        entry_head;
    logic [2:0]  removed_count;
    logic [12:0] entries_in_use;

    dir_scoreboard sb;
    int          cycles = 0;
    logic [39:0] recent_off [8];
    int          hot_bucket;

    localparam int LIMIT = 2000000;

    set_assoc_cache_directory_core i_dut (.*);

    always #5 clk = ~clk;

    // Bound the run length
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Check each response beat and toggle backpressure
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && out_ready)
                sb.check_response('{success, way, outcome, entry_offset, entry_scale,
                                    entry_blocks, entry_head, removed_count,
                                    entries_in_use});
            if ($urandom_range(0, 99) < 3)
                out_ready <= 0;
            else if ($urandom_range(0, 99) < 50)
                out_ready <= 1;
        end
    end

    function automatic int gap_len();
        if ($urandom_range(0, 99) < 90)
            return $urandom_range(0, 2);
        return $urandom_range(5, 40);
    endfunction

    // Send one request beat, wait for its acceptance, then drop valid
    task automatic send_req(logic [2:0] rq, logic [9:0] bkt, logic [11:0] tg,
                            logic [39:0] off, logic [39:0] bytes,
                            logic [39:0] voff, logic any, bit idle);
        int g;
        g = idle ? gap_len() : 0;
        repeat (g) @(posedge clk);
        in_valid <= 1;
        req_type <= rq;
        bucket <= bkt;
        key_tag <= tg;
        store_offset <= off;
        doc_bytes <= bytes;
        known_offset <= voff;
        match_any <= any;
        do @(posedge clk); while (!in_ready);
        sb.note_request(rq, bkt, tg, off, bytes, voff, any);
        in_valid <= 0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    // Random request biased toward a few hot buckets and small tags
    task automatic random_req(bit idle);
        logic [2:0]  rq;
        logic [9:0]  bkt;
        logic [11:0] tg;
        logic [39:0] off, bytes, voff;
        int          p;
        p = $urandom_range(0, 99);
        if (p < 30) rq = sacd_pkg::REQ_PROBE;
        else if (p < 65) rq = sacd_pkg::REQ_INSERT;
        else if (p < 78) rq = sacd_pkg::REQ_REMOVE;
        else if (p < 90) rq = sacd_pkg::REQ_REMOVE_AT;
        else if (p < 95) rq = sacd_pkg::REQ_TOGGLE;
        else rq = 3'($urandom_range(5, 7));
        bkt = ($urandom_range(0, 3) != 0) ? 10'(hot_bucket + $urandom_range(0, 3))
                                          : 10'($urandom_range(0, 1023));
        tg = ($urandom_range(0, 3) != 0) ? 12'($urandom_range(0, 5))
                                         : 12'($urandom_range(0, 4095));
        off = ($urandom_range(0, 1) != 0) ? recent_off[$urandom_range(0, 7)]
                                          : {8'($urandom_range(0, 255)), $urandom()};
        if ($urandom_range(0, 49) == 0)
            off = 0;
        case ($urandom_range(0, 3))
            0: bytes = 40'($urandom_range(0, 40000));
            1: bytes = 40'($urandom_range(0, 300000));
            2: bytes = {8'($urandom_range(0, 255)), $urandom()};
            default: bytes = 40'hFF_FFFF_FFFF;
        endcase
        voff = ($urandom_range(0, 1) != 0) ? recent_off[$urandom_range(0, 7)]
                                           : {8'($urandom_range(0, 255)), $urandom()};
        if (rq == sacd_pkg::REQ_INSERT)
            recent_off[$urandom_range(0, 7)] = off;
        send_req(rq, bkt, tg, off, bytes, voff, 1'($urandom_range(0, 1)), idle);
    endtask

    initial
    begin
        sb = new();
        hot_bucket = 0;
        foreach (recent_off[i])
            recent_off[i] = 40'(i + 1);
        repeat (4) @(posedge clk);
        rst_n <= 1;

        // Directed: fill a bucket, collide, evict, stale, sizes, remove paths
        send_req(sacd_pkg::REQ_PROBE, 10'd0, 12'd0, 40'd0, 40'd0, 40'd0, 1'b0, 1'b0);
        send_req(sacd_pkg::REQ_INSERT, 10'd0, 12'd1, 40'd0, 40'd100, 40'd0, 1'b0, 1'b0);
        send_req(sacd_pkg::REQ_INSERT, 10'd0, 12'd1, 40'd100, 40'd0, 40'd0, 1'b0, 1'b0);
        send_req(sacd_pkg::REQ_INSERT, 10'd0, 12'd1, 40'd200, 40'd32768, 40'd0,
                 1'b0, 1'b0);
        send_req(sacd_pkg::REQ_INSERT, 10'd0, 12'd1, 40'd300, 40'd32769, 40'd0,
                 1'b1, 1'b0);
        send_req(sacd_pkg::REQ_INSERT, 10'd0, 12'd2, 40'd50, 40'd262144, 40'd0,
                 1'b0, 1'b0);
        send_req(sacd_pkg::REQ_INSERT, 10'd0, 12'd3, 40'd400, 40'd262145, 40'd0,
                 1'b0, 1'b0);
        send_req(sacd_pkg::REQ_INSERT, 10'd0, 12'd3, 40'd500, 40'hFF_FFFF_FFFF, 40'd1,
                 1'b0, 1'b0);
        send_req(sacd_pkg::REQ_INSERT, 10'd0, 12'd9, 40'hFF_FFFF_FFFF, 40'd1, 40'd0,
                 1'b0, 1'b0);
        send_req(sacd_pkg::REQ_INSERT, 10'd0, 12'd3, 40'd600, 40'd513, 40'd500,
                 1'b0, 1'b0);
        send_req(sacd_pkg::REQ_PROBE, 10'd0, 12'd3, 40'd0, 40'd0, 40'd0, 1'b0, 1'b0);
        send_req(sacd_pkg::REQ_TOGGLE, 10'd0, 12'd0, 40'd0, 40'd0, 40'd0, 1'b0, 1'b0);
        send_req(sacd_pkg::REQ_PROBE, 10'd0, 12'd3, 40'd0, 40'd0, 40'd0, 1'b0, 1'b0);
        send_req(sacd_pkg::REQ_INSERT, 10'd0, 12'd7, 40'd700, 40'd1000, 40'd0,
                 1'b0, 1'b0);
        send_req(sacd_pkg::REQ_REMOVE_AT, 10'd0, 12'd3, 40'd0, 40'd0, 40'd0, 1'b0, 1'b0);
        send_req(sacd_pkg::REQ_REMOVE_AT, 10'd0, 12'd3, 40'd600, 40'd0, 40'd0,
                 1'b0, 1'b0);
        send_req(sacd_pkg::REQ_REMOVE, 10'd0, 12'd7, 40'd0, 40'd0, 40'd0, 1'b0, 1'b0);
        send_req(sacd_pkg::REQ_REMOVE, 10'd0, 12'd55, 40'd0, 40'd0, 40'd0, 1'b0, 1'b0);
        send_req(3'd5, 10'd1023, 12'hFFF, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF,
                 40'hFF_FFFF_FFFF, 1'b1, 1'b0);
        send_req(3'd7, 10'd1023, 12'hFFF, 40'd0, 40'd0, 40'd0, 1'b0, 1'b0);
        send_req(sacd_pkg::REQ_INSERT, 10'd1023, 12'hFFF, 40'hFF_FFFF_FFFF,
                 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 1'b1, 1'b0);
        send_req(sacd_pkg::REQ_PROBE, 10'd1023, 12'hFFF, 40'd0, 40'd0, 40'd0,
                 1'b1, 1'b0);

        // Random phases, moving the hot bucket group and pausing for drains
        for (int k = 0; k < 1400; k++) begin
            if (k % 200 == 0)
                hot_bucket = $urandom_range(0, 1020);
            if (k == 700)
                drain();
            random_req((k / 100) % 3 != 0);
        end
        drain();
        repeat (20) @(posedge clk);
        $display("covered %0d responses across probe, insert, remove and phase toggles",
                 sb.checked);
        $display("final live entries %0d, mismatches %0d", sb.live, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// ===== set_assoc_cache_directory_core.f =====
hw/rtl/sacd_pkg.sv
hw/rtl/sacd_ctrl.sv
hw/rtl/sacd_datapath.sv
hw/rtl/set_assoc_cache_directory_core.sv
hw/rtl/sacd_checker.sv
tb/tb.sv
